@@ sv/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FFPRA_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("%m: check failed");
`define FFPRA_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("%m: check failed");
`else
`define FFPRA_ASSERT(lbl, ck, rn, prop)
`define FFPRA_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

@@ sv/ffpra_pkg.sv @@
package ffpra_pkg;
  localparam int PAGE_TOTAL = 1024;
  localparam int WBITS     = 8;
  localparam int NCELL     = PAGE_TOTAL / WBITS;
  localparam int AW        = 10;
  localparam int CW        = 11;
  localparam int KW        = 7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
endpackage

@@ sv/first_fit_page_run_allocator_core.sv @@
// channel | dir | tdata (low bit up)                          | tuser
// in      | in  | page_count[10:0] page_index[20:11] pad       | mode
// out     | out | status[1:0] start_page[11:2] freed_pages[22:12] pad | -
// cfg     | in  | region_pages[10:0]                          | -
// Bitmap sits in a ring of 128 cells of 8 pages; one pass rotates it once.
// Allocate: scan pass plus mark pass; no fit found: scan pass only; zero
// or oversize count: answered without a pass. Free: read plus clear pass;
// page outside the region: answered without a pass.
// After reset the run-length memory is cleared, with in_tready low.
// One item at a time; a held output stalls the next result only.
`include "assert_macros.svh"
module first_fit_page_run_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // page_count, page_index
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status, start_page, freed_pages
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);
  import ffpra_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MARK = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_FREE = 3'd5;
  localparam logic [2:0] S_WIPE = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]    st_r;
  logic [CW-1:0] region_r, limit;
  logic [AW-1:0] clr_r;
  logic [KW-1:0] k_r;
  logic [CW-1:0] cnt_r, run_r, first_r;
  logic          found_r;
  logic [AW-1:0] lo_r;
  logic [AW+1:0] hi_r;
  logic [CW-1:0] rd_r;
  logic [1:0]    rs_r;
  logic [AW-1:0] rp_r;
  logic [CW-1:0] rf_r;
  logic          ov_r;
  logic [1:0]    os_r;
  logic [AW-1:0] op_r;
  logic [CW-1:0] of_r;

  logic [CW-1:0] rl_mem [PAGE_TOTAL];

  logic [WBITS-1:0] q [NCELL];
  logic [WBITS-1:0] head_new;
  logic             shift;
  logic [CW-1:0]    run_n, first_n;
  logic             found_n;

  assign limit = (region_r > CW'(PAGE_TOTAL)) ? CW'(PAGE_TOTAL) : region_r;
  assign shift = (st_r == S_SCAN) || (st_r == S_MARK) || (st_r == S_WIPE);

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == NCELL - 1) begin : g_tail
      ffpra_cell u_cell (.clk, .rst_n, .shift, .d(head_new), .q(q[i]));
    end else begin : g_mid
      ffpra_cell u_cell (.clk, .rst_n, .shift, .d(q[i+1]), .q(q[i]));
    end
  end

  ffpra_scan u_scan (
    .word(q[0]), .widx(k_r), .limit, .cnt(cnt_r), .run_in(run_r),
    .first_in(first_r), .found_in(found_r), .run_out(run_n),
    .first_out(first_n), .found_out(found_n)
  );

  always_comb begin
    logic [AW+1:0] p;
    logic          hit;
    head_new = q[0];
    for (int j = 0; j < WBITS; j++) begin
      p   = {2'b00, k_r, 3'(j)};
      hit = (p >= {2'b00, lo_r}) && (p < hi_r);
      if (st_r == S_MARK && hit) head_new[j] = 1'b1;
      if (st_r == S_WIPE && hit) head_new[j] = 1'b0;
    end
  end

  assign in_tready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (st_r == S_CLR) begin
      rl_mem[clr_r] <= '0;
    end else if (st_r == S_MARK && k_r == KW'(NCELL - 1)) begin
      rl_mem[lo_r] <= cnt_r;
    end else if (st_r == S_FREE) begin
      rl_mem[lo_r] <= '0;
    end
    rd_r <= rl_mem[lo_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLR;
      region_r <= CW'(PAGE_TOTAL);
      clr_r    <= '0;
      k_r      <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) region_r <= cfg_wdata;
      if (st_r == S_OUT && (!ov_r || out_tready)) begin
        ov_r <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        ov_r <= 1'b0;
      end
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(PAGE_TOTAL - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            cnt_r   <= in_tdata[10:0];
            lo_r    <= in_tdata[20:11];
            run_r   <= '0;
            first_r <= '0;
            found_r <= 1'b0;
            rp_r    <= '0;
            rf_r    <= '0;
            if (in_tuser == MODE_ALLOC) begin
              if (in_tdata[10:0] == '0 || in_tdata[10:0] > limit) begin
                rs_r <= ST_NO_SPACE;
                st_r <= S_OUT;
              end else begin
                st_r <= S_SCAN;
              end
            end else if ({1'b0, in_tdata[20:11]} >= limit) begin
              rs_r <= ST_OUTSIDE;
              st_r <= S_OUT;
            end else begin
              st_r <= S_RD;
            end
          end
        end
        S_SCAN: begin
          run_r   <= run_n;
          first_r <= first_n;
          found_r <= found_n;
          k_r     <= k_r + KW'(1);
          if (k_r == KW'(NCELL - 1)) begin
            lo_r <= first_n[AW-1:0];
            hi_r <= {1'b0, first_n} + {1'b0, cnt_r};
            if (found_n) begin
              st_r <= S_MARK;
            end else begin
              rs_r <= ST_NO_SPACE;
              st_r <= S_OUT;
            end
          end
        end
        S_MARK: begin
          k_r <= k_r + KW'(1);
          if (k_r == KW'(NCELL - 1)) begin
            rs_r <= ST_OK;
            rp_r <= lo_r;
            st_r <= S_OUT;
          end
        end
        S_RD: st_r <= S_FREE;
        S_FREE: begin
          hi_r <= {2'b00, lo_r} + {1'b0, rd_r};
          rf_r <= rd_r;
          st_r <= S_WIPE;
        end
        S_WIPE: begin
          k_r <= k_r + KW'(1);
          if (k_r == KW'(NCELL - 1)) begin
            rs_r <= ST_OK;
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ov_r || out_tready) begin
            os_r <= rs_r;
            op_r <= rp_r;
            of_r <= rf_r;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, of_r, op_r, os_r};

  `FFPRA_ASSERT(a_ring_home, clk, rst_n, (st_r == S_IDLE) |-> (k_r == '0))
  `FFPRA_ASSERT(a_no_take_clr, clk, rst_n, (st_r == S_CLR) |-> !in_tready)
  `FFPRA_ASSERT(a_mark_found, clk, rst_n, (st_r == S_MARK) |-> found_r)
  `FFPRA_ASSERT(a_mark_ok, clk, rst_n,
    (st_r == S_MARK && k_r == KW'(NCELL - 1)) |=> (rs_r == ST_OK && st_r == S_OUT))
endmodule

@@ sv/ffpra_cell.sv @@
module ffpra_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift,
  input  logic [ffpra_pkg::WBITS-1:0] d,
  output logic [ffpra_pkg::WBITS-1:0] q
);
  import ffpra_pkg::*;

  logic [WBITS-1:0] used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (shift) begin
      used_r <= d;
    end
  end

  assign q = used_r;
endmodule

@@ sv/ffpra_scan.sv @@
module ffpra_scan (
  input  logic [ffpra_pkg::WBITS-1:0] word,
  input  logic [ffpra_pkg::KW-1:0]    widx,
  input  logic [ffpra_pkg::CW-1:0]    limit,
  input  logic [ffpra_pkg::CW-1:0]    cnt,
  input  logic [ffpra_pkg::CW-1:0]    run_in,
  input  logic [ffpra_pkg::CW-1:0]    first_in,
  input  logic                        found_in,
  output logic [ffpra_pkg::CW-1:0]    run_out,
  output logic [ffpra_pkg::CW-1:0]    first_out,
  output logic                        found_out
);
  import ffpra_pkg::*;

  always_comb begin
    logic [CW-1:0] p;
    run_out   = run_in;
    first_out = first_in;
    found_out = found_in;
    for (int j = 0; j < WBITS; j++) begin
      p = {1'b0, widx, 3'(j)};
      if (p < limit && !found_out) begin
        if (word[j]) begin
          run_out   = '0;
          first_out = p + CW'(1);
        end else begin
          run_out = run_out + CW'(1);
          if (run_out == cnt) found_out = 1'b1;
        end
      end
    end
  end
endmodule
